>>> design/rau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_pkg: shared types and constants for the rational arithmetic unit
// Operation and status codes, sequencer states and datapath widths.
// ----------------------------------------------------------------------------
package rau_pkg;

   localparam int OPERAND_WIDTH_DEF = 32;
   localparam int FIELD_W           = 32;
   localparam int WORD_W            = 64;
   localparam int DEN_W             = 63;
   localparam int ALU_W             = WORD_W + 1;
   localparam int CNT_W             = $clog2(WORD_W);
   localparam int REQ_DATA_W        = 4 * FIELD_W;
   localparam int RSP_DATA_W        = 128;

   typedef enum logic [1:0] {
      MODE_ADD,
      MODE_SUB,
      MODE_MUL,
      MODE_DIV
   } mode_type;

   typedef enum logic {
      STATUS_OK,
      STATUS_INF
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL0,
      ST_MUL1,
      ST_MUL2,
      ST_MUL3,
      ST_CHECK,
      ST_ABSN,
      ST_ABSD,
      ST_TWOS,
      ST_ODDU,
      ST_GCD,
      ST_GDONE,
      ST_DIVN,
      ST_DIVD,
      ST_SIGN,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic [ALU_W-1:0] a;
      logic [ALU_W-1:0] b;
      logic             sub;
   } alu_req_type;

endpackage

>>> design/rau_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_mul: shared signed multiplier
// One signed product per cycle, registered at the output.
// ----------------------------------------------------------------------------
module rau_mul #(
   parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic signed [OPERAND_WIDTH-1:0]   mul_a,
   input  logic signed [OPERAND_WIDTH-1:0]   mul_b,
   output logic signed [2*OPERAND_WIDTH-1:0] prod_ff
);

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

endmodule

>>> design/rau_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_alu: shared add/subtract unit
// Adds or subtracts two 65-bit operands; carry out high means no borrow.
// ----------------------------------------------------------------------------
module rau_alu (
   input  rau_pkg::alu_req_type          alu_req,
   output logic [rau_pkg::ALU_W-1:0]     alu_sum,
   output logic                          alu_carry
);

   localparam int SUM_W = rau_pkg::ALU_W + 1;

   logic [rau_pkg::ALU_W-1:0] op_b;

   assign op_b = alu_req.sub ? ~alu_req.b : alu_req.b;
   assign {alu_carry, alu_sum} = SUM_W'(alu_req.a) + SUM_W'(op_b) + SUM_W'(alu_req.sub);

endmodule

>>> design/rational_arithmetic_unit_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_core: fraction add/sub/mul/div with gcd reduction
// Forms cross products, moves the sign to the numerator and reduces the
// fraction with a binary gcd and two restoring divisions.
//
//  channel | direction | word contents
//  req     | in        | tdata: a_num, a_den, b_num, b_den; tuser: mode
//  rsp     | out       | tdata: res_num, res_den; tuser: status
//
// A word passes through the cross products, the two's-count, the gcd
// subtract/shift loop and two 64-step divisions; the shared 65-bit adder
// serves the gcd loop and gives one quotient bit per cycle in the divisions.
// Zero numerator or zero denominator results go from the check straight to output.
// reset clears the sequencer and the output valid; no clearing pass.
// A result waits in the output register; a stalled rsp holds only the last step.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_core #(
   parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // a_num[31:0], a_den[63:32], b_num[95:64], b_den[127:96]
   input  logic [rau_pkg::REQ_DATA_W-1:0]    req_tdata,
   // mode[1:0]
   input  logic [1:0]                        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // res_num[63:0], res_den[126:64], zero[127]
   output logic [rau_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // status[0]
   output logic                              rsp_tuser
);

   localparam int W  = rau_pkg::WORD_W;
   localparam int FW = rau_pkg::FIELD_W;
   localparam int CW = rau_pkg::CNT_W;
   localparam int AW = rau_pkg::ALU_W;
   localparam logic [CW-1:0] CNT_LAST = CW'(W - 1);

   rau_pkg::state_type  state_ff, state_in;
   rau_pkg::mode_type   mode_ff, mode_in;
   rau_pkg::status_type stat_ff, stat_in, rsp_stat_ff, rsp_stat_in;

   logic signed [OPERAND_WIDTH-1:0] an_ff, an_in, ad_ff, ad_in;
   logic signed [OPERAND_WIDTH-1:0] bn_ff, bn_in, bd_ff, bd_in;
   logic signed [OPERAND_WIDTH-1:0] mul_a, mul_b;
   logic signed [2*OPERAND_WIDTH-1:0] prod;
   logic signed [W-1:0] prod64;

   logic [W-1:0] n_ff, n_in, d_ff, d_in, u_ff, u_in, v_ff, v_in;
   logic [W-1:0] rem_ff, rem_in, quo_ff, quo_in, quo_step;
   logic [W-1:0] rsp_num_ff, rsp_num_in;
   logic [rau_pkg::DEN_W-1:0] rsp_den_ff, rsp_den_in;
   logic [CW-1:0] k_ff, k_in, cnt_ff, cnt_in;
   logic          neg_ff, neg_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_free;
   logic [AW-1:0] shifted;

   rau_pkg::alu_req_type alu_req;
   logic [AW-1:0] alu_sum;
   logic          alu_carry;

   rau_mul #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (prod)
   );

   rau_alu u_alu (
      .alu_req   (alu_req),
      .alu_sum   (alu_sum),
      .alu_carry (alu_carry)
   );

   assign prod64     = W'(prod);
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == rau_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_den_ff, rsp_num_ff};
   assign rsp_tuser  = rsp_stat_ff;
   assign shifted    = {rem_ff, quo_ff[W-1]};
   assign quo_step   = {quo_ff[W-2:0], alu_carry};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rau_pkg::ST_IDLE:  if (req_tvalid) state_in = rau_pkg::ST_MUL0;
         rau_pkg::ST_MUL0:  state_in = rau_pkg::ST_MUL1;
         rau_pkg::ST_MUL1:  state_in = rau_pkg::ST_MUL2;
         rau_pkg::ST_MUL2:  state_in = rau_pkg::ST_MUL3;
         rau_pkg::ST_MUL3:  state_in = rau_pkg::ST_CHECK;
         rau_pkg::ST_CHECK: begin
            if (d_ff == '0 || n_ff == '0) state_in = rau_pkg::ST_OUT;
            else state_in = rau_pkg::ST_ABSN;
         end
         rau_pkg::ST_ABSN:  state_in = rau_pkg::ST_ABSD;
         rau_pkg::ST_ABSD:  state_in = rau_pkg::ST_TWOS;
         rau_pkg::ST_TWOS:  if (u_ff[0] || v_ff[0]) state_in = rau_pkg::ST_ODDU;
         rau_pkg::ST_ODDU:  if (u_ff[0]) state_in = rau_pkg::ST_GCD;
         rau_pkg::ST_GCD:   if (v_ff == '0) state_in = rau_pkg::ST_GDONE;
         rau_pkg::ST_GDONE: state_in = rau_pkg::ST_DIVN;
         rau_pkg::ST_DIVN:  if (cnt_ff == CNT_LAST) state_in = rau_pkg::ST_DIVD;
         rau_pkg::ST_DIVD:  if (cnt_ff == CNT_LAST) state_in = rau_pkg::ST_SIGN;
         rau_pkg::ST_SIGN:  state_in = rau_pkg::ST_OUT;
         rau_pkg::ST_OUT:   if (rsp_free) state_in = rau_pkg::ST_IDLE;
         default:           state_in = rau_pkg::ST_IDLE;
      endcase
   end

   // datapath controls
   always_comb begin
      mode_in      = mode_ff;
      an_in        = an_ff;
      ad_in        = ad_ff;
      bn_in        = bn_ff;
      bd_in        = bd_ff;
      n_in         = n_ff;
      d_in         = d_ff;
      u_in         = u_ff;
      v_in         = v_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      k_in         = k_ff;
      cnt_in       = cnt_ff;
      neg_in       = neg_ff;
      stat_in      = stat_ff;
      rsp_num_in   = rsp_num_ff;
      rsp_den_in   = rsp_den_ff;
      rsp_stat_in  = rsp_stat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      mul_a        = an_ff;
      mul_b        = bd_ff;
      alu_req      = '0;
      case (state_ff)
         rau_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               mode_in = rau_pkg::mode_type'(req_tuser);
               an_in   = req_tdata[0 +: OPERAND_WIDTH];
               ad_in   = req_tdata[FW +: OPERAND_WIDTH];
               bn_in   = req_tdata[2*FW +: OPERAND_WIDTH];
               bd_in   = req_tdata[3*FW +: OPERAND_WIDTH];
            end
         end
         rau_pkg::ST_MUL0: begin
            mul_a = an_ff;
            mul_b = (mode_ff == rau_pkg::MODE_MUL) ? bn_ff : bd_ff;
         end
         rau_pkg::ST_MUL1: begin
            n_in  = prod64;
            mul_a = bn_ff;
            mul_b = ad_ff;
         end
         rau_pkg::ST_MUL2: begin
            alu_req.a   = {1'b0, n_ff};
            alu_req.b   = {1'b0, prod64};
            alu_req.sub = (mode_ff == rau_pkg::MODE_SUB);
            if (mode_ff == rau_pkg::MODE_ADD || mode_ff == rau_pkg::MODE_SUB) begin
               n_in = alu_sum[W-1:0];
            end
            mul_a = ad_ff;
            mul_b = (mode_ff == rau_pkg::MODE_DIV) ? bn_ff : bd_ff;
         end
         rau_pkg::ST_MUL3: begin
            d_in = prod64;
         end
         rau_pkg::ST_CHECK: begin
            k_in    = '0;
            neg_in  = n_ff[W-1] ^ d_ff[W-1];
            stat_in = rau_pkg::STATUS_OK;
            if (d_ff == '0) begin
               // infinite: numerator becomes the sign of n
               stat_in = rau_pkg::STATUS_INF;
               if (n_ff == '0) n_in = '0;
               else if (n_ff[W-1]) n_in = '1;
               else n_in = W'(1);
            end else if (n_ff == '0) begin
               d_in = W'(1);
            end
         end
         rau_pkg::ST_ABSN: begin
            alu_req.b   = {1'b0, n_ff};
            alu_req.sub = 1'b1;
            if (n_ff[W-1]) n_in = alu_sum[W-1:0];
            u_in = n_ff[W-1] ? alu_sum[W-1:0] : n_ff;
         end
         rau_pkg::ST_ABSD: begin
            alu_req.b   = {1'b0, d_ff};
            alu_req.sub = 1'b1;
            if (d_ff[W-1]) d_in = alu_sum[W-1:0];
            v_in = d_ff[W-1] ? alu_sum[W-1:0] : d_ff;
         end
         rau_pkg::ST_TWOS: begin
            // strip common factors of two, count them in k
            if (!u_ff[0] && !v_ff[0]) begin
               u_in = u_ff >> 1;
               v_in = v_ff >> 1;
               k_in = k_ff + CW'(1);
            end
         end
         rau_pkg::ST_ODDU: begin
            if (!u_ff[0]) u_in = u_ff >> 1;
         end
         rau_pkg::ST_GCD: begin
            alu_req.a   = {1'b0, v_ff};
            alu_req.b   = {1'b0, u_ff};
            alu_req.sub = 1'b1;
            if (v_ff != '0) begin
               if (!v_ff[0]) begin
                  v_in = v_ff >> 1;
               end else if (!alu_carry) begin
                  // keep u the smaller odd value
                  u_in = v_ff;
                  v_in = u_ff;
               end else begin
                  v_in = alu_sum[W-1:0];
               end
            end
         end
         rau_pkg::ST_GDONE: begin
            u_in   = u_ff << k_ff;
            rem_in = '0;
            quo_in = n_ff;
            cnt_in = '0;
         end
         rau_pkg::ST_DIVN, rau_pkg::ST_DIVD: begin
            alu_req.a   = shifted;
            alu_req.b   = {1'b0, u_ff};
            alu_req.sub = 1'b1;
            rem_in = alu_carry ? alu_sum[W-1:0] : shifted[W-1:0];
            quo_in = quo_step;
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CNT_LAST) begin
               if (state_ff == rau_pkg::ST_DIVN) begin
                  n_in   = quo_step;
                  quo_in = d_ff;
                  rem_in = '0;
                  cnt_in = '0;
               end else begin
                  d_in = quo_step;
               end
            end
         end
         rau_pkg::ST_SIGN: begin
            alu_req.b   = {1'b0, n_ff};
            alu_req.sub = 1'b1;
            if (neg_ff) n_in = alu_sum[W-1:0];
         end
         rau_pkg::ST_OUT: begin
            if (rsp_free) begin
               rsp_num_in   = n_ff;
               rsp_den_in   = d_ff[rau_pkg::DEN_W-1:0];
               rsp_stat_in  = stat_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rau_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      an_ff       <= an_in;
      ad_ff       <= ad_in;
      bn_ff       <= bn_in;
      bd_ff       <= bd_in;
      n_ff        <= n_in;
      d_ff        <= d_in;
      u_ff        <= u_in;
      v_ff        <= v_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      k_ff        <= k_in;
      cnt_ff      <= cnt_in;
      neg_ff      <= neg_in;
      stat_ff     <= stat_in;
      rsp_num_ff  <= rsp_num_in;
      rsp_den_ff  <= rsp_den_in;
      rsp_stat_ff <= rsp_stat_in;
   end

endmodule

>>> dv/rational_arithmetic_unit_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_core_tb: self-checking bench for the fraction unit
// Offers fraction pairs with add, subtract, multiply and divide. It starts
// with hand-picked corner cases and then sends random operands. Each accepted
// word is reduced by a local integer model. Every result word is compared
// with the oldest pending fraction. Both channels stall at random. There is
// one long output hold-off and a few pauses that wait for the unit to drain.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_core_tb;

   localparam int RANDOM_WORDS = 1030;
   localparam int QUIET_LIMIT  = 20000;
   localparam int HOLDOFF_LEN  = 1500;
   localparam int SETTLE_LEN   = 500;

   localparam logic signed [31:0] OPND_MAX  = 32'sh7fffffff;
   localparam logic signed [31:0] OPND_NEG  = 32'sh80000000;

   typedef struct {
      rau_pkg::mode_type  mode;
      logic signed [31:0] a_num;
      logic signed [31:0] a_den;
      logic signed [31:0] b_num;
      logic signed [31:0] b_den;
      bit                 drain_first;
   } operand_set_type;

   typedef struct {
      logic [63:0]         res_num;
      logic [62:0]         res_den;
      rau_pkg::status_type status;
   } reduced_type;

   logic                             clock      = 1'b0;
   logic                             reset      = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [rau_pkg::REQ_DATA_W-1:0]   req_tdata  = '0;
   logic [1:0]                       req_tuser  = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [rau_pkg::RSP_DATA_W-1:0]   rsp_tdata;
   logic                             rsp_tuser;

   operand_set_type operand_queue[$];
   reduced_type     fractions_due[$];
   operand_set_type on_offer;

   int unsigned total_words   = 0;
   int unsigned words_sent    = 0;
   int unsigned words_checked = 0;
   int unsigned infinite_seen = 0;
   int unsigned zero_seen     = 0;
   int unsigned quiet_cycles  = 0;
   int unsigned holdoff_left  = 0;
   bit          holdoff_done  = 1'b0;
   int          errors        = 0;

   rational_arithmetic_unit_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Cross products, sign moved to the numerator, reduced by Euclid's gcd.
   function automatic reduced_type rational_reduce(operand_set_type op);
      logic signed [63:0] an, ad, bn, bd;
      logic [63:0]        n, d, nm, dm, x, y, r, qn;
      reduced_type        res;
      an = op.a_num;
      ad = op.a_den;
      bn = op.b_num;
      bd = op.b_den;
      case (op.mode)
         rau_pkg::MODE_ADD: begin
            n = an * bd + bn * ad;
            d = ad * bd;
         end
         rau_pkg::MODE_SUB: begin
            n = an * bd - bn * ad;
            d = ad * bd;
         end
         rau_pkg::MODE_MUL: begin
            n = an * bn;
            d = ad * bd;
         end
         default: begin
            n = an * bd;
            d = ad * bn;
         end
      endcase
      if (d == 64'd0) begin
         res.res_num = (n == 64'd0) ? 64'd0 : (n[63] ? '1 : 64'd1);
         res.res_den = '0;
         res.status  = rau_pkg::STATUS_INF;
         return res;
      end
      res.status = rau_pkg::STATUS_OK;
      if (n == 64'd0) begin
         res.res_num = 64'd0;
         res.res_den = 63'd1;
         return res;
      end
      nm = n[63] ? 64'd0 - n : n;
      dm = d[63] ? 64'd0 - d : d;
      x  = nm;
      y  = dm;
      while (y != 64'd0) begin
         r = x % y;
         x = y;
         y = r;
      end
      qn          = nm / x;
      res.res_num = (n[63] ^ d[63]) ? 64'd0 - qn : qn;
      res.res_den = 63'(dm / x);
      return res;
   endfunction

   function automatic logic signed [31:0] random_operand();
      int unsigned pick;
      logic [31:0] raw;
      pick = $urandom_range(99);
      raw  = $urandom;
      if (pick < 5)
         return 32'sd0;
      else if (pick < 12) begin
         case ($urandom_range(4))
            0:       return OPND_MAX;
            1:       return -OPND_MAX;
            2:       return OPND_NEG;
            3:       return 32'sd1;
            default: return -32'sd1;
         endcase
      end else if (pick < 50)
         return 32'(int'($urandom_range(200)) - 100);
      else if (pick < 70)
         return $signed(raw) >>> $urandom_range(31);
      else
         return raw;
   endfunction

   task automatic queue_op(rau_pkg::mode_type m, int an, int ad, int bn, int bd, bit drain);
      operand_set_type op;
      op.mode        = m;
      op.a_num       = an;
      op.a_den       = ad;
      op.b_num       = bn;
      op.b_den       = bd;
      op.drain_first = drain;
      operand_queue.push_back(op);
   endtask

   task automatic flag_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
         errors++;
      end
   endtask

   // Driver: hold a word until taken, then load the next one or idle.
   always @(posedge clock) begin : drive_proc
      int unsigned sent_now;
      bit          idle_now;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         sent_now = words_sent;
         if (req_tvalid && req_tready) begin
            fractions_due.push_back(rational_reduce(on_offer));
            sent_now++;
            words_sent <= sent_now;
         end
         if (!req_tvalid || req_tready) begin
            idle_now = (sent_now >= 400 && sent_now < 600) ? 1'b0 : ($urandom_range(99) < 34);
            if (operand_queue.size() != 0 && !idle_now &&
                (!operand_queue[0].drain_first || words_checked == sent_now)) begin
               on_offer = operand_queue.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {on_offer.b_den, on_offer.b_num, on_offer.a_den, on_offer.a_num};
               req_tuser  <= on_offer.mode;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random back-pressure, one long hold-off so the unit backs up.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (holdoff_left != 0) begin
         holdoff_left <= holdoff_left - 1;
         rsp_tready   <= 1'b0;
      end else if (!holdoff_done && words_checked >= 150) begin
         holdoff_done <= 1'b1;
         holdoff_left <= HOLDOFF_LEN;
         rsp_tready   <= 1'b0;
      end else if (words_checked >= 400 && words_checked < 600) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= 34);
      end
   end

   always @(posedge clock) begin : check_proc
      reduced_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (fractions_due.size() == 0) begin
            $display("%0t: result word with nothing pending, expected none, got %h / %b",
                     $time, rsp_tdata, rsp_tuser);
            errors++;
         end else begin
            want = fractions_due.pop_front();
            flag_field("res_num", want.res_num, rsp_tdata[63:0]);
            flag_field("res_den", {1'b0, want.res_den}, rsp_tdata[127:64]);
            flag_field("status", 64'(want.status), 64'(rsp_tuser));
         end
         if (rsp_tuser == rau_pkg::STATUS_INF)
            infinite_seen++;
         else if (rsp_tdata[63:0] == 64'd0)
            zero_seen++;
         words_checked <= words_checked + 1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      operand_set_type op;
      queue_op(rau_pkg::MODE_ADD, 1, 2, 1, 3, 1'b0);
      queue_op(rau_pkg::MODE_SUB, 1, 2, 1, 2, 1'b0);
      queue_op(rau_pkg::MODE_MUL, 2, -3, 3, 4, 1'b0);
      queue_op(rau_pkg::MODE_DIV, 3, 4, 0, 5, 1'b0);           // divide by a zero fraction
      queue_op(rau_pkg::MODE_DIV, 0, 4, 0, 5, 1'b0);           // zero over zero
      queue_op(rau_pkg::MODE_ADD, -3, 0, 1, 2, 1'b0);          // zero input denominator
      queue_op(rau_pkg::MODE_MUL, 0, 0, 5, 3, 1'b0);
      queue_op(rau_pkg::MODE_ADD, 1, -2, 1, 2, 1'b0);          // zero sum, negative denominator
      queue_op(rau_pkg::MODE_MUL, OPND_MAX, OPND_MAX, OPND_MAX, OPND_MAX, 1'b0);
      queue_op(rau_pkg::MODE_MUL, OPND_MAX, 1, OPND_MAX, 1, 1'b0);
      queue_op(rau_pkg::MODE_ADD, -OPND_MAX, OPND_MAX, -OPND_MAX, 1, 1'b0);
      queue_op(rau_pkg::MODE_SUB, OPND_MAX, -OPND_MAX, -OPND_MAX, OPND_MAX, 1'b0);
      queue_op(rau_pkg::MODE_DIV, OPND_MAX, -OPND_MAX, -OPND_MAX, 1, 1'b0);
      // sum wraps
      queue_op(rau_pkg::MODE_ADD, OPND_NEG, OPND_NEG, OPND_NEG, OPND_NEG, 1'b0);
      queue_op(rau_pkg::MODE_SUB, OPND_NEG, 1, OPND_MAX, OPND_NEG, 1'b0);
      queue_op(rau_pkg::MODE_MUL, OPND_NEG, 1, OPND_NEG, -1, 1'b0);
      queue_op(rau_pkg::MODE_DIV, OPND_NEG, OPND_NEG, 1, OPND_NEG, 1'b0);
      queue_op(rau_pkg::MODE_DIV, 5, 7, -10, 21, 1'b0);
      queue_op(rau_pkg::MODE_MUL, 6, 35, 14, 9, 1'b0);
      queue_op(rau_pkg::MODE_SUB, -1, -1, 1, 1, 1'b1);         // wait for drain first
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         op.mode        = rau_pkg::mode_type'($urandom_range(3));
         op.a_num       = random_operand();
         op.a_den       = random_operand();
         op.b_num       = random_operand();
         op.b_den       = random_operand();
         op.drain_first = (i == 300 || i == 700);
         operand_queue.push_back(op);
      end
      total_words = operand_queue.size();

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      while (words_sent != total_words || words_checked != words_sent)
         @(posedge clock);
      repeat (SETTLE_LEN) @(posedge clock);
      if (fractions_due.size() != 0) begin
         $display("%0t: %0d results never arrived, expected 0 pending, got %0d",
                  $time, fractions_due.size(), fractions_due.size());
         errors++;
      end
      $display("summary: %0d words sent, %0d results checked over all four operations",
               words_sent, words_checked);
      $display("summary: %0d infinite and %0d zero results, %0d errors",
               infinite_seen, zero_seen, errors);
      if (errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

>>> filelist.f
design/rau_pkg.sv
design/rau_mul.sv
design/rau_alu.sv
design/rational_arithmetic_unit_core.sv
dv/rational_arithmetic_unit_core_tb.sv
